// ===== hdl/dlwc_pkg.sv =====
`default_nettype none
package dlwc_pkg;

   localparam int NUM_SENSORS     = 8;
   localparam int SAMPLE_BITS_DEF = 10;
   localparam int TIME_W          = 32;
   localparam int COUNT_W         = 32;
   localparam int IDX_W           = $clog2(NUM_SENSORS);
   localparam int WEIGHT_W        = 17;
   localparam int FRAC_W          = 16;
   localparam int ACC_W           = 64;
   localparam int HALF_W          = 32;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 32;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LENGTH   = 2'd0,
      CSR_SAMPLE_INTERVAL = 2'd1,
      CSR_BLEND_WEIGHT    = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_START  = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_USE,
      ST_DIV,
      ST_BLEND,
      ST_DONE
   } core_state_type;

   typedef enum logic [1:0] {
      BL_IDLE,
      BL_LO,
      BL_HI,
      BL_RND
   } blend_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage
`default_nettype wire

// ===== hdl/dlwc_req_if.sv =====
`default_nettype none
interface dlwc_req_if import dlwc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic [TIME_W-1:0]      current_time;
   logic [SAMPLE_BITS-1:0] sensor_0;
   logic [SAMPLE_BITS-1:0] sensor_1;
   logic [SAMPLE_BITS-1:0] sensor_2;
   logic [SAMPLE_BITS-1:0] sensor_3;
   logic [SAMPLE_BITS-1:0] sensor_4;
   logic [SAMPLE_BITS-1:0] sensor_5;
   logic [SAMPLE_BITS-1:0] sensor_6;
   logic [SAMPLE_BITS-1:0] sensor_7;

   modport source (
      output valid, cmd, current_time,
      output sensor_0, sensor_1, sensor_2, sensor_3,
      output sensor_4, sensor_5, sensor_6, sensor_7,
      input  ready
   );

   modport sink (
      input  valid, cmd, current_time,
      input  sensor_0, sensor_1, sensor_2, sensor_3,
      input  sensor_4, sensor_5, sensor_6, sensor_7,
      output ready
   );
endinterface
`default_nettype wire

// ===== hdl/dlwc_rsp_if.sv =====
`default_nettype none
interface dlwc_rsp_if import dlwc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   in_window;
   logic [SAMPLE_BITS-1:0] dark_0;
   logic [SAMPLE_BITS-1:0] dark_1;
   logic [SAMPLE_BITS-1:0] dark_2;
   logic [SAMPLE_BITS-1:0] dark_3;
   logic [SAMPLE_BITS-1:0] dark_4;
   logic [SAMPLE_BITS-1:0] dark_5;
   logic [SAMPLE_BITS-1:0] dark_6;
   logic [SAMPLE_BITS-1:0] dark_7;

   modport source (
      output valid, in_window,
      output dark_0, dark_1, dark_2, dark_3, dark_4, dark_5, dark_6, dark_7,
      input  ready
   );

   modport sink (
      input  valid, in_window,
      input  dark_0, dark_1, dark_2, dark_3, dark_4, dark_5, dark_6, dark_7,
      output ready
   );
endinterface
`default_nettype wire

// ===== hdl/dlwc_csr_if.sv =====
`default_nettype none
interface dlwc_csr_if import dlwc_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface
`default_nettype wire

// ===== hdl/dlwc_ram.sv =====
`default_nettype none
module dlwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/dlwc_div.sv =====
`default_nettype none
module dlwc_div import dlwc_pkg::*; #(
   parameter int DIVIDEND_W = 58,
   parameter int DIVISOR_W  = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic      [DIVIDEND_W-1:0] quotient,
   output unit_sts_type               sts
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] work_ff, work_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;

   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   assign rem_sh = {rem_ff, work_ff[DIVIDEND_W-1]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         work_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[DIVIDEND_W-2:0], ge};
         rem_in  = ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient = work_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule
`default_nettype wire

// ===== hdl/dlwc_blend.sv =====
`default_nettype none
module dlwc_blend import dlwc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int AVG_W       = COUNT_W + SAMPLE_BITS + FRAC_W
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [AVG_W-1:0]       avg,
   input  wire logic [SAMPLE_BITS-1:0] base,
   input  wire logic [WEIGHT_W-1:0]    weight,
   output logic      [SAMPLE_BITS-1:0] result,
   output unit_sts_type                sts
);

   localparam int PROD_W = WEIGHT_W + HALF_W;
   localparam int TERM_W = SAMPLE_BITS + WEIGHT_W;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
   localparam logic [ACC_W-1:0]       ROUND_HALF = ACC_W'(1) << (HALF_W - 1);

   blend_state_type state_ff, state_in;
   logic                   done_ff, done_in;
   logic [WEIGHT_W-1:0]    w_ff, w_in;
   logic [AVG_W-1:0]       avg_ff, avg_in;
   logic [SAMPLE_BITS-1:0] base_ff, base_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [SAMPLE_BITS-1:0] result_ff, result_in;

   logic [HALF_W-1:0] mul_b;
   logic [PROD_W-1:0] prod;
   logic [TERM_W-1:0] term;
   logic [ACC_W-1:0]  rnd;
   logic [HALF_W-1:0] rnd_hi;

   assign mul_b  = (state_ff == BL_LO) ? avg_ff[HALF_W-1:0] : HALF_W'(avg_ff[AVG_W-1:HALF_W]);
   assign prod   = PROD_W'(w_ff) * PROD_W'(mul_b);
   assign term   = TERM_W'(base_ff) * TERM_W'(WEIGHT_ONE - w_ff);
   assign rnd    = acc_ff + ROUND_HALF;
   assign rnd_hi = rnd[ACC_W-1:HALF_W];

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      w_in      = w_ff;
      avg_in    = avg_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      result_in = result_ff;
      case (state_ff)
         BL_IDLE: begin
            if (start) begin
               w_in     = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
               avg_in   = avg;
               base_in  = base;
               state_in = BL_LO;
            end
         end
         BL_LO: begin
            acc_in   = (ACC_W'(term) << FRAC_W) + ACC_W'(prod);
            state_in = BL_HI;
         end
         BL_HI: begin
            acc_in   = acc_ff + (ACC_W'(prod) << HALF_W);
            state_in = BL_RND;
         end
         BL_RND: begin
            result_in = (rnd_hi > HALF_W'(SAMPLE_MAX)) ? SAMPLE_MAX : rnd_hi[SAMPLE_BITS-1:0];
            done_in   = 1'b1;
            state_in  = BL_IDLE;
         end
         default: begin
            state_in = BL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      avg_ff    <= avg_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign result   = result_ff;
   assign sts.busy = (state_ff != BL_IDLE);
   assign sts.done = done_ff;

endmodule
`default_nettype wire

// ===== hdl/dark_level_window_calibrator_core.sv =====
// Each sensor passes a read step and a use step on the state memories; a new request is
// taken only in idle, once the last result has been handed to the response register.
// A window close with samples sends each sensor through the shared one-bit-per-cycle
// divider and then the two-pass blend multiplier.
// Reset: state, settings, window start and sample count go to zero; baselines and sums
// read as zero until written, with no clearing pass.
`default_nettype none
module dark_level_window_calibrator_core import dlwc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   dlwc_req_if.sink    req_bus,
   dlwc_rsp_if.source  rsp_bus,
   dlwc_csr_if.sink    csr_bus
);

   localparam int SUM_W = COUNT_W + SAMPLE_BITS;
   localparam int AVG_W = SUM_W + FRAC_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SENSORS - 1);

   core_state_type state_ff, state_in;

   logic [TIME_W-1:0]   window_length_ff, window_length_in;
   logic [TIME_W-1:0]   sample_interval_ff, sample_interval_in;
   logic [WEIGHT_W-1:0] blend_weight_ff, blend_weight_in;

   logic [TIME_W-1:0]      window_start_ff, window_start_in;
   logic [COUNT_W-1:0]     samples_taken_ff, samples_taken_in;
   logic [NUM_SENSORS-1:0] sum_valid_ff, sum_valid_in;
   logic [NUM_SENSORS-1:0] base_valid_ff, base_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]                        idx_ff, idx_in;
   cmd_type                                 cmd_ff, cmd_in;
   logic [TIME_W-1:0]                       time_ff, time_in;
   logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [TIME_W-1:0]                       elapsed_ff, elapsed_in;
   logic [TIME_W-1:0]                       due_ff, due_in;
   logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] dark_ff, dark_in;
   logic [SAMPLE_BITS-1:0]                  base_hold_ff, base_hold_in;
   logic                                    rsp_live_ff, rsp_live_in;
   logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] rsp_dark_ff, rsp_dark_in;

   logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] req_sample;
   logic                   req_xfer;
   logic                   csr_xfer;
   logic                   is_sample;
   logic                   window_end;
   logic                   take_sample;
   logic                   advance;

   logic                   sum_we;
   logic [SUM_W-1:0]       sum_wdata;
   logic [SUM_W-1:0]       sum_q;
   logic [SUM_W-1:0]       sum_rd;
   logic                   base_we;
   logic [SAMPLE_BITS-1:0] base_wdata;
   logic [SAMPLE_BITS-1:0] base_q;
   logic [SAMPLE_BITS-1:0] base_rd;

   logic                   div_start;
   logic [AVG_W-1:0]       div_quotient;
   unit_sts_type           div_sts;
   logic                   blend_start;
   logic [SAMPLE_BITS-1:0] blend_result;
   unit_sts_type           blend_sts;

   assign req_sample[0] = req_bus.sensor_0;
   assign req_sample[1] = req_bus.sensor_1;
   assign req_sample[2] = req_bus.sensor_2;
   assign req_sample[3] = req_bus.sensor_3;
   assign req_sample[4] = req_bus.sensor_4;
   assign req_sample[5] = req_bus.sensor_5;
   assign req_sample[6] = req_bus.sensor_6;
   assign req_sample[7] = req_bus.sensor_7;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_xfer      = csr_bus.valid && csr_bus.ready;

   assign is_sample   = (cmd_ff == CMD_SAMPLE);
   assign window_end  = is_sample && (elapsed_ff >= window_length_ff);
   assign take_sample = is_sample && !window_end && (due_ff < elapsed_ff);

   assign sum_rd  = sum_valid_ff[idx_ff] ? sum_q : '0;
   assign base_rd = base_valid_ff[idx_ff] ? base_q : '0;

   dlwc_ram #(
      .WIDTH (SUM_W),
      .DEPTH (NUM_SENSORS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (idx_ff),
      .wr_data (sum_wdata),
      .rd_addr (idx_ff),
      .rd_data (sum_q)
   );

   dlwc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (NUM_SENSORS)
   ) u_base_ram (
      .clock   (clock),
      .wr_en   (base_we),
      .wr_addr (idx_ff),
      .wr_data (base_wdata),
      .rd_addr (idx_ff),
      .rd_data (base_q)
   );

   dlwc_div #(
      .DIVIDEND_W (AVG_W),
      .DIVISOR_W  (COUNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_rd, {FRAC_W{1'b0}}}),
      .divisor  (samples_taken_ff),
      .quotient (div_quotient),
      .sts      (div_sts)
   );

   dlwc_blend #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AVG_W       (AVG_W)
   ) u_blend (
      .clock  (clock),
      .reset  (reset),
      .start  (blend_start),
      .avg    (div_quotient),
      .base   (base_hold_ff),
      .weight (blend_weight_ff),
      .result (blend_result),
      .sts    (blend_sts)
   );

   always_comb begin
      window_length_in   = window_length_ff;
      sample_interval_in = sample_interval_ff;
      blend_weight_in    = blend_weight_ff;
      if (csr_xfer) begin
         case (csr_bus.index)
            CSR_WINDOW_LENGTH:   window_length_in   = csr_bus.data[TIME_W-1:0];
            CSR_SAMPLE_INTERVAL: sample_interval_in = csr_bus.data[TIME_W-1:0];
            CSR_BLEND_WEIGHT:    blend_weight_in    = csr_bus.data[WEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in         = state_ff;
      window_start_in  = window_start_ff;
      samples_taken_in = samples_taken_ff;
      sum_valid_in     = sum_valid_ff;
      base_valid_in    = base_valid_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      idx_in           = idx_ff;
      cmd_in           = cmd_ff;
      time_in          = time_ff;
      sample_in        = sample_ff;
      elapsed_in       = elapsed_ff;
      due_in           = due_ff;
      dark_in          = dark_ff;
      base_hold_in     = base_hold_ff;
      rsp_live_in      = rsp_live_ff;
      rsp_dark_in      = rsp_dark_ff;
      sum_we           = 1'b0;
      sum_wdata        = sum_rd + SUM_W'(sample_ff[idx_ff]);
      base_we          = 1'b0;
      base_wdata       = sample_ff[idx_ff];
      div_start        = 1'b0;
      blend_start      = 1'b0;
      advance          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in    = cmd_type'(req_bus.cmd);
               time_in   = req_bus.current_time;
               sample_in = req_sample;
               idx_in    = '0;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            elapsed_in = time_ff - window_start_ff;
            due_in     = samples_taken_ff * sample_interval_ff;
            state_in   = ST_READ;
         end
         ST_READ: begin
            state_in = ST_USE;
         end
         ST_USE: begin
            if (!is_sample) begin
               base_we         = 1'b1;
               dark_in[idx_ff] = sample_ff[idx_ff];
               advance         = 1'b1;
            end else if (window_end && (samples_taken_ff != '0)) begin
               div_start    = 1'b1;
               base_hold_in = base_rd;
               state_in     = ST_DIV;
            end else begin
               sum_we          = take_sample;
               dark_in[idx_ff] = base_rd;
               advance         = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               blend_start = 1'b1;
               state_in    = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (blend_sts.done) begin
               base_we         = 1'b1;
               base_wdata      = blend_result;
               dark_in[idx_ff] = blend_result;
               advance         = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_live_in  = !window_end;
               rsp_dark_in  = dark_ff;
               if (!is_sample || window_end) begin
                  window_start_in  = time_ff;
                  samples_taken_in = '0;
                  sum_valid_in     = '0;
               end else if (take_sample) begin
                  samples_taken_in = samples_taken_ff + COUNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (sum_we) begin
         sum_valid_in[idx_ff] = 1'b1;
      end
      if (base_we) begin
         base_valid_in[idx_ff] = 1'b1;
      end
      if (advance) begin
         if (idx_ff == IDX_LAST) begin
            state_in = ST_DONE;
         end else begin
            idx_in   = idx_ff + IDX_W'(1);
            state_in = ST_READ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         window_length_ff   <= '0;
         sample_interval_ff <= '0;
         blend_weight_ff    <= '0;
         window_start_ff    <= '0;
         samples_taken_ff   <= '0;
         sum_valid_ff       <= '0;
         base_valid_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         window_length_ff   <= window_length_in;
         sample_interval_ff <= sample_interval_in;
         blend_weight_ff    <= blend_weight_in;
         window_start_ff    <= window_start_in;
         samples_taken_ff   <= samples_taken_in;
         sum_valid_ff       <= sum_valid_in;
         base_valid_ff      <= base_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cmd_ff       <= cmd_in;
      time_ff      <= time_in;
      sample_ff    <= sample_in;
      elapsed_ff   <= elapsed_in;
      due_ff       <= due_in;
      dark_ff      <= dark_in;
      base_hold_ff <= base_hold_in;
      rsp_live_ff  <= rsp_live_in;
      rsp_dark_ff  <= rsp_dark_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.in_window = rsp_live_ff;
   assign rsp_bus.dark_0    = rsp_dark_ff[0];
   assign rsp_bus.dark_1    = rsp_dark_ff[1];
   assign rsp_bus.dark_2    = rsp_dark_ff[2];
   assign rsp_bus.dark_3    = rsp_dark_ff[3];
   assign rsp_bus.dark_4    = rsp_dark_ff[4];
   assign rsp_bus.dark_5    = rsp_dark_ff[5];
   assign rsp_bus.dark_6    = rsp_dark_ff[6];
   assign rsp_bus.dark_7    = rsp_dark_ff[7];

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the done state");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (samples_taken_ff != $past(samples_taken_ff)) |->
         (samples_taken_ff == $past(samples_taken_ff) + COUNT_W'(1)) ||
         (samples_taken_ff == '0))
      else $error("sample count moved by more than one");

   a_sum_write_live: assert property (@(posedge clock) disable iff (reset)
      sum_we |-> (state_ff == ST_USE) && take_sample)
      else $error("sum written outside a live sample transfer");

endmodule
`default_nettype wire
